// ===== design/button_debounce_long_press_defines.svh =====
// Assertion macros shared by the debouncer modules.
// Needs signals clk and rst in the module that expands them.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define BDLP_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define BDLP_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bdlp_pkg.sv =====
// Shared types and constants for the two-button debouncer.
// No dependencies; imported by every module of the block.
package bdlp_pkg;

  localparam int BUTTON_COUNT = 2;
  localparam int PIN_COUNT    = 2;
  localparam int MASK_W       = 2;
  localparam int IDX_W        = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam int CNT_W        = 16;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  // Operation codes carried by an item
  typedef logic [1:0] op_t;
  localparam op_t OP_TICK       = 2'd0;
  localparam op_t OP_TAKE_SHORT = 2'd1;
  localparam op_t OP_TAKE_LONG  = 2'd2;

  // Register indexes (byte address 4*i)
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_DEBOUNCE   = 2'd0;
  localparam reg_idx_t REG_LONG_PRESS = 2'd1;
  localparam reg_idx_t REG_LEVEL      = 2'd2;

  localparam logic [CNT_W-1:0] DEBOUNCE_RESET   = 16'd10;
  localparam logic [CNT_W-1:0] LONG_PRESS_RESET = 16'd100;

  // Per-button mode
  typedef enum logic [3:0] {
    MODE_IDLE     = 4'b0001,
    MODE_DEBOUNCE = 4'b0010,
    MODE_PRESSED  = 4'b0100,
    MODE_LONG     = 4'b1000
  } mode_t;

  // Pending event kind
  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_SHORT = 2'd1,
    PEND_LONG  = 2'd2
  } pend_t;

  typedef struct packed {
    logic [CNT_W-1:0] debounce_ticks;
    logic [CNT_W-1:0] long_press_ticks;
    logic             pressed_level;
  } cfg_t;

  // What one lane reports after the item
  typedef struct packed {
    logic took;
    logic is_short;
    logic is_long;
  } lane_res_t;

  typedef struct packed {
    logic              taken;
    logic [MASK_W-1:0] pending_short;
    logic [MASK_W-1:0] pending_long;
  } res_t;

endpackage

// ===== design/bdlp_lane.sv =====
// One button lane: sample history, debounce/long-press countdown, pending event.
// Depends on bdlp_pkg and the assertion macros header.
`include "button_debounce_long_press_defines.svh"

module bdlp_lane (
  input  logic               clk,
  input  logic               rst,
  input  logic               step_en,
  input  bdlp_pkg::op_t      op,
  input  logic               addressed,
  input  logic               level,
  input  bdlp_pkg::cfg_t     cfg,
  output bdlp_pkg::lane_res_t res
);
  import bdlp_pkg::*;

  logic [2:0]       history, history_next, hist_shift;
  mode_t            mode, mode_next;
  logic [CNT_W-1:0] count, count_next;
  pend_t            pend, pend_next;
  pend_t            want;
  logic             held;
  logic             took;

  // Next-state logic for one item
  always_comb begin
    hist_shift   = {history[1:0], level};
    held         = (level == cfg.pressed_level);
    want         = (op == OP_TAKE_SHORT) ? PEND_SHORT : PEND_LONG;
    history_next = history;
    mode_next    = mode;
    count_next   = count;
    pend_next    = pend;
    took         = 1'b0;
    if (step_en) begin
      case (op) inside
        OP_TICK: begin
          history_next = hist_shift;
          unique case (mode)
            MODE_IDLE: begin
              if (hist_shift == {3{cfg.pressed_level}}) begin
                mode_next  = MODE_DEBOUNCE;
                count_next = cfg.debounce_ticks;
              end
            end
            MODE_DEBOUNCE: begin
              if (count != '0) begin
                count_next = count - 1'b1;
              end else if (held) begin
                mode_next  = MODE_PRESSED;
                count_next = cfg.long_press_ticks;
                pend_next  = PEND_SHORT;
              end else begin
                mode_next = MODE_IDLE;
              end
            end
            MODE_PRESSED: begin
              if (!held) begin
                mode_next = MODE_IDLE;
              end else if (count != '0) begin
                count_next = count - 1'b1;
              end else begin
                mode_next = MODE_LONG;
                pend_next = PEND_LONG;
              end
            end
            MODE_LONG: begin
              if (!held) begin
                mode_next = MODE_IDLE;
              end else begin
                pend_next  = PEND_LONG;
                count_next = cfg.long_press_ticks;
              end
            end
            default: begin
              mode_next = MODE_IDLE;
            end
          endcase
        end
        OP_TAKE_SHORT, OP_TAKE_LONG: begin
          if (addressed && pend == want) begin
            pend_next = PEND_NONE;
            took      = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Lane state
  always_ff @(posedge clk) begin
    if (rst) begin
      history <= 3'b111;
      mode    <= MODE_IDLE;
      count   <= '0;
      pend    <= PEND_NONE;
    end else begin
      history <= history_next;
      mode    <= mode_next;
      count   <= count_next;
      pend    <= pend_next;
    end
  end

  // Report post-item view to the merge stage
  assign res.took     = took;
  assign res.is_short = (pend_next == PEND_SHORT);
  assign res.is_long  = (pend_next == PEND_LONG);

  `BDLP_CHECK_NEXT(a_take_clears, took, pend == PEND_NONE, "take did not clear pending event")
  `BDLP_CHECK_NEXT(a_long_repeat, step_en && op == OP_TICK && mode == MODE_LONG && held, pend == PEND_LONG && count == $past(cfg.long_press_ticks), "held long press did not repeat")
  `BDLP_CHECK_NOW(a_short_on_confirm, (pend != PEND_SHORT) ##1 (pend == PEND_SHORT), mode == MODE_PRESSED, "short event without confirmed press")

endmodule

// ===== design/bdlp_merge.sv =====
// Merge stage: combines lane reports into one result and holds it in a
// two-entry output stage. Depends on bdlp_pkg and the assertion macros header.
`include "button_debounce_long_press_defines.svh"

module bdlp_merge (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     push,
  input  bdlp_pkg::lane_res_t [bdlp_pkg::BUTTON_COUNT-1:0] lanes,
  output logic                                     in_ready,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic                                     taken,
  output logic [bdlp_pkg::MASK_W-1:0]              pending_short,
  output logic [bdlp_pkg::MASK_W-1:0]              pending_long
);
  import bdlp_pkg::*;

  res_t res;
  res_t out_data, skid_data;
  logic skid_valid;
  logic pop;

  // Any lane that took its event makes the item taken;
  // event masks cover the first MASK_W buttons only
  always_comb begin
    res = '0;
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      res.taken = res.taken | lanes[b].took;
      if (b < MASK_W) begin
        res.pending_short[b] = lanes[b].is_short;
        res.pending_long[b]  = lanes[b].is_long;
      end
    end
  end

  assign pop      = out_valid && out_ready;
  assign in_ready = !skid_valid;

  // Output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data  <= res;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= res;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign taken         = out_data.taken;
  assign pending_short = out_data.pending_short;
  assign pending_long  = out_data.pending_long;

  `BDLP_CHECK_NOW(a_skid_behind_out, skid_valid, out_valid, "skid entry held with empty output")
  `BDLP_CHECK_NEXT(a_stall_fills_skid, push && out_valid && !out_ready, skid_valid && out_valid, "stalled item was not parked")
  `BDLP_CHECK_NEXT(a_skid_drains, skid_valid && out_ready, !skid_valid && out_valid && out_data == $past(skid_data), "skid entry not moved to output")

endmodule

// ===== design/button_debounce_long_press.sv =====
// Two-button debouncer with short and long press events.
// Each accepted item's result is registered into the output register, or into the skid entry if the output stalls.
// Throughput: one item per cycle; a two-entry output stage keeps in_ready
// high while one result waits, so only two unaccepted results stall input.
// Reset (rst, synchronous): lanes idle, history released, registers 10/100/0.
module button_debounce_long_press (
  input  logic                          clk,
  input  logic                          rst,
  // item input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    operation,
  input  logic                          button_index,
  input  logic [bdlp_pkg::PIN_COUNT-1:0] pin_levels,
  // result output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          taken,
  output logic [bdlp_pkg::MASK_W-1:0]   pending_short,
  output logic [bdlp_pkg::MASK_W-1:0]   pending_long,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bdlp_pkg::ADDR_W-1:0]   paddr,
  input  logic [bdlp_pkg::DATA_W-1:0]   pwdata,
  output logic [bdlp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import bdlp_pkg::*;

  cfg_t                          cfg;
  reg_idx_t                      reg_idx;
  logic                          cfg_wr;
  logic                          push;
  lane_res_t [BUTTON_COUNT-1:0]  lanes;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= DEBOUNCE_RESET;
      cfg.long_press_ticks <= LONG_PRESS_RESET;
      cfg.pressed_level    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DEBOUNCE:   cfg.debounce_ticks   <= pwdata[CNT_W-1:0];
        REG_LONG_PRESS: cfg.long_press_ticks <= pwdata[CNT_W-1:0];
        REG_LEVEL:      cfg.pressed_level    <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_idx)
      REG_DEBOUNCE:   prdata = {{(DATA_W-CNT_W){1'b0}}, cfg.debounce_ticks};
      REG_LONG_PRESS: prdata = {{(DATA_W-CNT_W){1'b0}}, cfg.long_press_ticks};
      REG_LEVEL:      prdata = {{(DATA_W-1){1'b0}}, cfg.pressed_level};
      default:        prdata = '0;
    endcase
  end

  assign push = in_valid && in_ready;

  // One lane per button; buttons past the pin field sample pin 0
  for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_lane
    localparam int PIN_BIT = (b < PIN_COUNT) ? b : 0;
    bdlp_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .step_en   (push),
      .op        (op_t'(operation)),
      .addressed (IDX_W'(button_index) == IDX_W'(b)),
      .level     (pin_levels[PIN_BIT]),
      .cfg       (cfg),
      .res       (lanes[b])
    );
  end

  bdlp_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .lanes         (lanes),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .taken         (taken),
    .pending_short (pending_short),
    .pending_long  (pending_long)
  );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the two-button debouncer with long-press detection.
// Needs bdlp_pkg and button_debounce_long_press; keeps its own copy of the lane
// state and checks each result item against it.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bdlp_pkg::*;

  // Operation code with no meaning to the block
  localparam op_t OP_UNDEF = 2'd3;

  typedef struct packed {
    op_t        op;
    logic       idx;
    logic [1:0] pins;
  } item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             operation = OP_TICK;
  logic                   button_index = 1'b0;
  logic [PIN_COUNT-1:0]   pin_levels = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   taken;
  logic [MASK_W-1:0]      pending_short;
  logic [MASK_W-1:0]      pending_long;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_W-1:0]      paddr = '0;
  logic [DATA_W-1:0]      pwdata = '0;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  button_debounce_long_press dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .button_index(button_index), .pin_levels(pin_levels),
    .out_valid(out_valid), .out_ready(out_ready),
    .taken(taken), .pending_short(pending_short), .pending_long(pending_long),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5ns clk = ~clk;

  // Predictor copy of the registers and of each lane
  logic [CNT_W-1:0] cfg_debounce = DEBOUNCE_RESET;
  logic [CNT_W-1:0] cfg_long     = LONG_PRESS_RESET;
  logic             cfg_level    = 1'b0;
  logic [2:0]       lane_hist  [BUTTON_COUNT] = '{default: 3'b111};
  mode_t            lane_mode  [BUTTON_COUNT] = '{default: MODE_IDLE};
  logic [CNT_W-1:0] lane_count [BUTTON_COUNT] = '{default: '0};
  pend_t            lane_event [BUTTON_COUNT] = '{default: PEND_NONE};

  item_t press_script [$];
  res_t  event_masks_q [$];
  int    items_queued    = 0;
  int    reports_checked = 0;
  int    mismatches      = 0;
  int    send_idle_pct   = 0;
  int    rx_stall_pct    = 0;
  int    rx_hold_left    = 0;

  // Advance the lanes by one item and return the expected event masks
  function automatic res_t debounce_step(item_t it);
    res_t       r;
    logic [2:0] h;
    logic       lvl;
    logic       held;
    pend_t      want;
    r = '0;
    case (it.op)
      OP_TICK: begin
        for (int b = 0; b < BUTTON_COUNT; b++) begin
          lvl  = (b < PIN_COUNT) ? it.pins[b] : it.pins[0];
          h    = {lane_hist[b][1:0], lvl};
          held = (lvl == cfg_level);
          lane_hist[b] = h;
          case (lane_mode[b])
            MODE_IDLE: begin
              if (h == {3{cfg_level}}) begin
                lane_mode[b]  = MODE_DEBOUNCE;
                lane_count[b] = cfg_debounce;
              end
            end
            MODE_DEBOUNCE: begin
              if (lane_count[b] != 0) lane_count[b]--;
              else if (held) begin
                lane_mode[b]  = MODE_PRESSED;
                lane_count[b] = cfg_long;
                lane_event[b] = PEND_SHORT;
              end else lane_mode[b] = MODE_IDLE;
            end
            MODE_PRESSED: begin
              if (!held) lane_mode[b] = MODE_IDLE;
              else if (lane_count[b] != 0) lane_count[b]--;
              else begin
                lane_mode[b]  = MODE_LONG;
                lane_event[b] = PEND_LONG;
              end
            end
            default: begin
              // held long: the event repeats on every tick
              if (!held) lane_mode[b] = MODE_IDLE;
              else begin
                lane_event[b] = PEND_LONG;
                lane_count[b] = cfg_long;
              end
            end
          endcase
        end
      end
      OP_TAKE_SHORT, OP_TAKE_LONG: begin
        want = (it.op == OP_TAKE_SHORT) ? PEND_SHORT : PEND_LONG;
        if (lane_event[it.idx] == want) begin
          lane_event[it.idx] = PEND_NONE;
          r.taken = 1'b1;
        end
      end
      default: ;
    endcase
    for (int b = 0; b < BUTTON_COUNT && b < MASK_W; b++) begin
      if (lane_event[b] == PEND_SHORT) r.pending_short[b] = 1'b1;
      else if (lane_event[b] == PEND_LONG) r.pending_long[b] = 1'b1;
    end
    return r;
  endfunction

  function automatic void queue_item(op_t op, logic idx, logic [1:0] pins);
    item_t it;
    it.op   = op;
    it.idx  = idx;
    it.pins = pins;
    press_script.push_back(it);
    items_queued++;
  endfunction

  // Raw pin levels with the buttons in mask pressed, the rest released
  function automatic logic [1:0] pins_for(logic [1:0] mask);
    return cfg_level ? mask : ~mask;
  endfunction

  function automatic void queue_random_take();
    queue_item($urandom_range(0, 1) ? OP_TAKE_LONG : OP_TAKE_SHORT,
               1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
  endfunction

  // Mostly clean presses of random length with takes mixed in, some bounce and noise
  task automatic queue_press_traffic(int count, int max_hold);
    int         target;
    int         kind;
    int         hold;
    logic [1:0] mask;
    target = press_script.size() + count;
    while (press_script.size() < target) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        mask = 2'($urandom_range(1, 3));
        repeat ($urandom_range(0, 3)) queue_item(OP_TICK, 1'b0, 2'($urandom_range(0, 3)));
        hold = $urandom_range(0, max_hold);
        for (int k = 0; k < hold; k++) begin
          if ($urandom_range(0, 5) == 0) queue_random_take();
          else queue_item(OP_TICK, 1'($urandom_range(0, 1)), pins_for(mask));
        end
        repeat ($urandom_range(1, 3)) queue_item(OP_TICK, 1'b0, pins_for(2'b00));
        repeat ($urandom_range(1, 3)) queue_random_take();
      end else if (kind < 8) begin
        repeat ($urandom_range(1, 6)) queue_item(OP_TICK, 1'b0, 2'($urandom_range(0, 3)));
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 4)) queue_random_take();
      end else begin
        queue_item(OP_UNDEF, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
      end
    end
  endtask

  // Setup then access phase; the register takes the value at the end of the access phase
  task automatic write_register(reg_idx_t r, logic [CNT_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_DEBOUNCE:   cfg_debounce = v;
      REG_LONG_PRESS: cfg_long = v;
      REG_LEVEL:      cfg_level = v[0];
      default: ;
    endcase
  endtask

  task automatic set_timing(logic [CNT_W-1:0] deb, logic [CNT_W-1:0] lng, logic lvl);
    write_register(REG_DEBOUNCE, deb);
    write_register(REG_LONG_PRESS, lng);
    write_register(REG_LEVEL, {15'd0, lvl});
  endtask

  task automatic wait_drained();
    while (reports_checked < items_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic note_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Driver: next item from the script, predicted on acceptance
  always @(posedge clk) begin : drive_items
    item_t nxt;
    item_t seen;
    if (rst) in_valid <= 1'b0;
    else begin
      if (in_valid && in_ready) begin
        seen = {operation, button_index, pin_levels};
        event_masks_q.push_back(debounce_step(seen));
      end
      if (!in_valid || in_ready) begin
        if (press_script.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = press_script.pop_front();
          in_valid     <= 1'b1;
          operation    <= nxt.op;
          button_index <= nxt.idx;
          pin_levels   <= nxt.pins;
        end else in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted down here
  always @(posedge clk) begin
    if (rx_hold_left > 0) rx_hold_left <= rx_hold_left - 1;
  end

  // Monitor: compare each result item with the oldest expectation
  always @(posedge clk) begin : check_results
    res_t want;
    out_ready <= (rx_hold_left == 0) && ($urandom_range(0, 99) >= rx_stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (event_masks_q.size() == 0) note_error("result item with none expected");
      else begin
        want = event_masks_q.pop_front();
        reports_checked++;
        if (taken !== want.taken)
          note_error($sformatf("taken %b, expected %b", taken, want.taken));
        if (pending_short !== want.pending_short)
          note_error($sformatf("pending_short %b, expected %b",
                               pending_short, want.pending_short));
        if (pending_long !== want.pending_long)
          note_error($sformatf("pending_long %b, expected %b",
                               pending_long, want.pending_long));
      end
    end
  end

  // Stimulus phases
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset timing: long holds reach the long-press countdown of 100
    queue_press_traffic(300, 130);
    wait_drained();

    // Directed: zero delays so every mode is reached within a few ticks
    set_timing(16'd0, 16'd0, 1'b0);
    queue_item(OP_UNDEF, 1'b0, 2'b00);
    queue_item(OP_UNDEF, 1'b1, 2'b11);
    queue_item(OP_TAKE_SHORT, 1'b0, 2'b00);   // nothing pending
    queue_item(OP_TAKE_LONG, 1'b1, 2'b11);
    repeat (3) queue_item(OP_TICK, 1'b0, 2'b10);  // button 0 stable pressed
    queue_item(OP_TICK, 1'b0, 2'b10);         // confirmed: short event
    queue_item(OP_TAKE_LONG, 1'b0, 2'b00);    // wrong kind, stays
    queue_item(OP_TAKE_SHORT, 1'b1, 2'b00);   // other button has none
    queue_item(OP_TICK, 1'b1, 2'b10);         // long event replaces short
    repeat (3) queue_item(OP_TICK, 1'b0, 2'b00);  // button 1 pressed too, long repeats
    queue_item(OP_TICK, 1'b0, 2'b00);
    queue_item(OP_TAKE_SHORT, 1'b1, 2'b01);
    queue_item(OP_TAKE_LONG, 1'b0, 2'b10);
    queue_item(OP_TAKE_LONG, 1'b0, 2'b11);    // already cleared
    queue_item(OP_TICK, 1'b0, 2'b11);         // both released
    repeat (3) queue_item(OP_TICK, 1'b0, 2'b00);
    queue_item(OP_TICK, 1'b0, 2'b11);         // released during debounce
    queue_item(OP_TICK, 1'b1, 2'b01);
    queue_item(OP_UNDEF, 1'b1, 2'b01);
    wait_drained();

    // Active-high buttons, no idling
    set_timing(16'd3, 16'd5, 1'b1);
    queue_press_traffic(300, 20);
    wait_drained();

    // Sparse sender
    set_timing(CNT_W'($urandom_range(0, 6)), CNT_W'($urandom_range(0, 8)), 1'b0);
    send_idle_pct = 85;
    queue_press_traffic(300, 20);
    wait_drained();

    // Stalling receiver, with one long hold-off so the input backs up
    send_idle_pct = 0;
    rx_stall_pct  = 85;
    set_timing(CNT_W'($urandom_range(0, 6)), CNT_W'($urandom_range(0, 8)), 1'b1);
    queue_press_traffic(300, 20);
    @(posedge clk);
    rx_hold_left <= 300;
    wait_drained();

    // Both sides idling; the sender pauses midway until all results are in
    send_idle_pct = 29;
    rx_stall_pct  = 29;
    set_timing(CNT_W'($urandom_range(0, 6)), CNT_W'($urandom_range(0, 8)),
               1'($urandom_range(0, 1)));
    queue_press_traffic(150, 20);
    wait_drained();
    queue_press_traffic(150, 20);
    wait_drained();

    // Largest delays: counters run but never expire
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    set_timing(16'hFFFF, 16'hFFFF, 1'b0);
    queue_press_traffic(120, 30);
    wait_drained();

    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
